/* design/led_strip_effect_generator_defines.svh */
// Assertion macros shared by the LED strip effect generator RTL.
// Expects signals named clk and arst_n in the scope of use.
`ifndef LED_STRIP_EFFECT_GENERATOR_DEFINES_SVH
`define LED_STRIP_EFFECT_GENERATOR_DEFINES_SVH

// Checked only while out of reset.
`define LSEG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define LSEG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/lseg_pkg.sv */
// Package of the LED strip effect generator: register map, mode codes and
// shared control types. No dependencies.
package lseg_pkg;

	localparam int IDX_W = 6;
	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_POWER = 3'd0;
	localparam logic [2:0] REG_MODE = 3'd1;
	localparam logic [2:0] REG_COLOR = 3'd2;
	localparam logic [2:0] REG_INTERVAL = 3'd3;
	localparam logic [2:0] REG_DECAY = 3'd4;
	localparam logic [2:0] REG_SPACING = 3'd5;
	localparam logic [2:0] REG_STEP = 3'd6;
	localparam logic [2:0] REG_BACKWARD = 3'd7;

	localparam logic [2:0] FX_CHASE = 3'd0;
	localparam logic [2:0] FX_COMET = 3'd1;
	localparam logic [2:0] FX_BOUNCE = 3'd2;
	localparam logic [2:0] FX_THEATER = 3'd3;
	localparam logic [2:0] FX_RAINBOW = 3'd4;
	localparam logic [2:0] FX_BREATH = 3'd5;

	typedef struct packed {
		logic        power_enable;
		logic [2:0]  effect_mode;
		logic [23:0] base_color;
		logic [15:0] frame_interval_ms;
		logic [7:0]  tail_decay;
		logic [7:0]  theater_spacing;
		logic [15:0] phase_step;
		logic        move_backward;
	} cfg_t;

	// Side effects of a register write, valid in the cycle of the write.
	typedef struct packed {
		logic restart;
		logic clear_store;
		logic new_backward;
	} cfg_evt_t;

	// Per-pixel inputs of the color unit.
	typedef struct packed {
		logic [2:0]  mode;
		logic        at_head;
		logic        theater_hit;
		logic [7:0]  hue;
		logic [23:0] stored;
		logic        stored_valid;
		logic [23:0] breath_color;
	} pix_ctrl_t;

endpackage

/* design/lseg_if.sv */
// Handshake channel interfaces of the LED strip effect generator.
// Standalone; payload widths follow the item fields.
interface lseg_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	modport source(output valid, output now_ms, input ready);
	modport sink(input valid, input now_ms, output ready);
endinterface

interface lseg_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last_pixel;
	modport source(output valid, output pixel_index, output red, output green,
		output blue, output last_pixel, input ready);
	modport sink(input valid, input pixel_index, input red, input green,
		input blue, input last_pixel, output ready);
endinterface

/* design/lseg_regs.sv */
// APB-style configuration registers of the LED strip effect generator.
// Depends on lseg_pkg.
module lseg_regs import lseg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg,
	output cfg_evt_t          evt
);
	cfg_t       cfg_q;
	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[ADDR_W-1:2];
	assign cfg = cfg_q;

	always_comb begin
		evt.restart = wr;
		evt.clear_store = wr && (idx == REG_POWER) && !pwdata[0];
		evt.new_backward = (idx == REG_BACKWARD) ? pwdata[0] : cfg_q.move_backward;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{power_enable: 1'b0, effect_mode: 3'd0, base_color: 24'd0,
				frame_interval_ms: 16'd0, tail_decay: 8'd0, theater_spacing: 8'd3,
				phase_step: 16'd1, move_backward: 1'b0};
		end else if (wr) begin
			unique case (idx)
				REG_POWER:    cfg_q.power_enable <= pwdata[0];
				REG_MODE:     cfg_q.effect_mode <= pwdata[2:0];
				REG_COLOR:    cfg_q.base_color <= pwdata[23:0];
				REG_INTERVAL: cfg_q.frame_interval_ms <= pwdata[15:0];
				REG_DECAY:    cfg_q.tail_decay <= pwdata[7:0];
				REG_SPACING:  cfg_q.theater_spacing <= pwdata[7:0];
				REG_STEP:     cfg_q.phase_step <= pwdata[15:0];
				REG_BACKWARD: cfg_q.move_backward <= pwdata[0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_POWER:    prdata = {31'd0, cfg_q.power_enable};
			REG_MODE:     prdata = {29'd0, cfg_q.effect_mode};
			REG_COLOR:    prdata = {8'd0, cfg_q.base_color};
			REG_INTERVAL: prdata = {16'd0, cfg_q.frame_interval_ms};
			REG_DECAY:    prdata = {24'd0, cfg_q.tail_decay};
			REG_SPACING:  prdata = {24'd0, cfg_q.theater_spacing};
			REG_STEP:     prdata = {16'd0, cfg_q.phase_step};
			REG_BACKWARD: prdata = {31'd0, cfg_q.move_backward};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

/* design/lseg_pixel_unit.sv */
// Shared per-pixel color unit: picks one pixel's color for the active effect.
// Depends on lseg_pkg.
module lseg_pixel_unit import lseg_pkg::*; (
	input  pix_ctrl_t   ctrl,
	input  logic [23:0] base_color,
	input  logic [7:0]  tail_decay,
	output logic [23:0] color
);
	logic [7:0]  p;
	logic [7:0]  q;
	logic [7:0]  q3;
	logic [23:0] wheel;
	logic [23:0] faded;
	logic [23:0] old;

	always_comb begin
		p = 8'd255 - ctrl.hue;
		if (p < 8'd85) begin
			q = p;
		end else if (p < 8'd170) begin
			q = p - 8'd85;
		end else begin
			q = p - 8'd170;
		end
		q3 = 8'(q * 8'd3);
		if (p < 8'd85) begin
			wheel = {8'd255 - q3, 8'd0, q3};
		end else if (p < 8'd170) begin
			wheel = {8'd0, q3, 8'd255 - q3};
		end else begin
			wheel = {q3, 8'd255 - q3, 8'd0};
		end
	end

	always_comb begin
		old = ctrl.stored_valid ? ctrl.stored : 24'd0;
		for (int c = 0; c < 3; c++) begin
			faded[c*8 +: 8] = (old[c*8 +: 8] > tail_decay) ?
				old[c*8 +: 8] - tail_decay : 8'd0;
		end
	end

	always_comb begin
		case (ctrl.mode) inside
			FX_CHASE, FX_BOUNCE: color = ctrl.at_head ? base_color : 24'd0;
			FX_COMET:   color = ctrl.at_head ? base_color : faded;
			FX_THEATER: color = ctrl.theater_hit ? base_color : 24'd0;
			FX_RAINBOW: color = wheel;
			default:    color = ctrl.breath_color;
		endcase
	end

endmodule

/* design/lseg_rc_rom.sv */
// Raised-cosine ROM: sin^2(pi*p/1024) in unsigned Q0.16 for p in 0..512,
// filled at elaboration, registered read. Depends on lseg_pkg.
module lseg_rc_rom import lseg_pkg::*; (
	input  logic        clk,
	input  logic [9:0]  addr,
	output logic [15:0] data_q
);
	typedef logic [15:0] rc_tbl_t [0:512];

	function automatic rc_tbl_t build_tbl();
		rc_tbl_t            t;
		longint unsigned    x;
		longint unsigned    x2;
		longint unsigned    term;
		longint unsigned    s;
		longint unsigned    sq;
		longint             acc;
		for (int p = 0; p <= 512; p++) begin
			x = (longint'(p) * 64'd3373259426) >> 10;
			x2 = (x * x) >> 30;
			term = x;
			acc = longint'(term);
			term = ((term * x2) >> 30) / 6;   acc = acc - longint'(term);
			term = ((term * x2) >> 30) / 20;  acc = acc + longint'(term);
			term = ((term * x2) >> 30) / 42;  acc = acc - longint'(term);
			term = ((term * x2) >> 30) / 72;  acc = acc + longint'(term);
			term = ((term * x2) >> 30) / 110; acc = acc - longint'(term);
			term = ((term * x2) >> 30) / 156; acc = acc + longint'(term);
			s = (acc < 0) ? 64'd0 : longint'(acc);
			if (s > (64'd1 << 31)) begin
				s = 64'd1 << 31;
			end
			sq = (s * s + (64'd1 << 43)) >> 44;
			t[p] = (sq > 64'hFFFF) ? 16'hFFFF : sq[15:0];
		end
		return t;
	endfunction

	localparam rc_tbl_t TBL = build_tbl();

	always_ff @(posedge clk) begin
		data_q <= TBL[addr];
	end

endmodule

/* design/led_strip_effect_generator.sv */
// LED strip effect generator top: sequencer, frame store and output register.
// A timestamp transaction starts a frame; theater first reduces the head modulo the spacing
// (S_MOD), breath first reads the table and scales each channel (S_ROM, S_MUL). Then each pixel
// is read from the store (S_RD), written back and emitted (S_EMIT), held by output back-pressure.
// Reset (arst_n low, asynchronous) restores register defaults and empties the store.
// Depends on lseg_pkg, lseg_if, lseg_regs, lseg_pixel_unit, lseg_rc_rom.
`include "led_strip_effect_generator_defines.svh"
module led_strip_effect_generator import lseg_pkg::*; #(
	parameter int PIXEL_COUNT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	lseg_in_if.sink           in_ch,
	lseg_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(PIXEL_COUNT - 1);
	localparam logic [7:0] HUE_Q = 8'(256 / PIXEL_COUNT);
	localparam logic [6:0] HUE_R = 7'(256 % PIXEL_COUNT);
	localparam logic [6:0] PC7 = 7'(PIXEL_COUNT);

	typedef enum logic [2:0] {S_IDLE, S_MOD, S_ROM, S_MUL, S_RD, S_EMIT} state_t;

	cfg_t      cfg;
	cfg_evt_t  evt;
	state_t    state_q;
	pix_ctrl_t pctl;

	logic [23:0] store [0:63];
	logic [63:0] vld_q;
	logic [23:0] rd_q;
	logic        rvld_q;

	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] h_q;
	logic             down_q;
	logic [15:0]      phase_q;
	logic [31:0]      last_q;
	logic [IDX_W-1:0] cnt_q;
	logic [7:0]       t_q;
	logic [7:0]       hq_q;
	logic [6:0]       hr_q;
	logic [7:0]       ph_lo_q;
	logic [2:0]       mode_q;
	logic [9:0]       rom_addr_q;
	logic [15:0]      rc;
	logic [1:0]       ch_q;
	logic [23:0]      bcol_q;
	logic [23:0]      color;

	logic        ovalid_q;
	logic [5:0]  oidx_q;
	logic [23:0] ocol_q;
	logic        olast_q;

	logic        go;
	logic [7:0]  sp;
	logic [31:0] elapsed;
	logic [15:0] ph_b;
	logic [10:0] ph_map;
	logic        emit;
	logic [IDX_W-1:0] head_nx;
	logic [6:0]  hr_sum;
	logic [8:0]  t_inc;
	logic [23:0] mul_p;

	lseg_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg, .evt
	);

	lseg_rc_rom u_rom (.clk, .addr(rom_addr_q), .data_q(rc));

	assign pctl = '{mode: mode_q, at_head: (cnt_q == h_q), theater_hit: (t_q == 8'd0),
		hue: 8'(hq_q + ph_lo_q), stored: rd_q, stored_valid: rvld_q, breath_color: bcol_q};

	lseg_pixel_unit u_pix (
		.ctrl(pctl), .base_color(cfg.base_color), .tail_decay(cfg.tail_decay), .color
	);

	// A register write restarts the animation, so no timestamp is taken in that cycle.
	assign in_ch.ready = (state_q == S_IDLE) && !evt.restart;
	assign elapsed = in_ch.now_ms - last_q;
	assign go = in_ch.valid && in_ch.ready && cfg.power_enable &&
		(elapsed >= {16'd0, cfg.frame_interval_ms});
	assign sp = (cfg.theater_spacing == 8'd0) ? 8'd1 : cfg.theater_spacing;
	assign ph_b = {6'd0, 10'(phase_q[9:0] + cfg.phase_step[9:0])};
	assign ph_map = (ph_b[9:0] > 10'd512) ? 11'd1024 - {1'b0, ph_b[9:0]} : {1'b0, ph_b[9:0]};
	assign emit = (state_q == S_EMIT) && (!ovalid_q || out_ch.ready);
	assign hr_sum = hr_q + HUE_R;
	assign t_inc = {1'b0, t_q} + 9'd1;
	assign mul_p = (ch_q == 2'd0) ? cfg.base_color[23:16] * rc :
		(ch_q == 2'd1) ? cfg.base_color[15:8] * rc : cfg.base_color[7:0] * rc;

	always_comb begin
		if (down_q) begin
			head_nx = (head_q == '0) ? LAST : head_q - 1'b1;
		end else begin
			head_nx = (head_q >= LAST) ? '0 : head_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			h_q <= '0;
			down_q <= 1'b0;
			phase_q <= '0;
			last_q <= '0;
			cnt_q <= '0;
			t_q <= '0;
			hq_q <= '0;
			hr_q <= '0;
			ph_lo_q <= '0;
			rom_addr_q <= '0;
			ovalid_q <= 1'b0;
			vld_q <= '0;
			mode_q <= FX_CHASE;
			ch_q <= '0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			if (evt.restart) begin
				head_q <= '0;
				phase_q <= '0;
				down_q <= evt.new_backward;
				if (evt.clear_store) begin
					vld_q <= '0;
				end
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (go) begin
							last_q <= in_ch.now_ms;
							mode_q <= cfg.effect_mode;
							h_q <= head_q;
							cnt_q <= '0;
							t_q <= {2'd0, head_q};
							hq_q <= '0;
							hr_q <= '0;
							ph_lo_q <= phase_q[7:0];
							rom_addr_q <= ph_map[9:0];
							ch_q <= '0;
							case (cfg.effect_mode) inside
								FX_CHASE, FX_COMET: begin
									head_q <= head_nx;
									state_q <= S_RD;
								end
								FX_BOUNCE: begin
									if (down_q) begin
										if (head_q <= 6'd1) begin
											head_q <= '0;
											down_q <= 1'b0;
										end else begin
											head_q <= head_q - 1'b1;
										end
									end else if (head_q + 1'b1 >= LAST) begin
										head_q <= LAST;
										down_q <= 1'b1;
									end else begin
										head_q <= head_q + 1'b1;
									end
									state_q <= S_RD;
								end
								FX_THEATER: begin
									head_q <= head_nx;
									state_q <= S_MOD;
								end
								FX_RAINBOW: begin
									phase_q <= phase_q + cfg.phase_step;
									state_q <= S_RD;
								end
								FX_BREATH: begin
									phase_q <= ph_b;
									state_q <= S_ROM;
								end
								default: state_q <= S_IDLE;
							endcase
						end
					end
					S_MOD: begin
						// Reduce the head position modulo the spacing by repeated subtraction.
						if (t_q >= sp) begin
							t_q <= t_q - sp;
						end else begin
							state_q <= S_RD;
						end
					end
					S_ROM: state_q <= S_MUL;
					S_MUL: begin
						ch_q <= ch_q + 1'b1;
						if (ch_q == 2'd2) begin
							state_q <= S_RD;
						end
					end
					S_RD: state_q <= S_EMIT;
					S_EMIT: begin
						if (emit) begin
							vld_q[cnt_q] <= 1'b1;
							cnt_q <= cnt_q + 1'b1;
							t_q <= (t_inc == {1'b0, sp}) ? 8'd0 : t_inc[7:0];
							if (hr_sum >= PC7) begin
								hr_q <= hr_sum - PC7;
								hq_q <= hq_q + HUE_Q + 8'd1;
							end else begin
								hr_q <= hr_sum;
								hq_q <= hq_q + HUE_Q;
							end
							state_q <= (cnt_q == LAST) ? S_IDLE : S_RD;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			case (ch_q)
				2'd0:    bcol_q[23:16] <= mul_p[23:16];
				2'd1:    bcol_q[15:8] <= mul_p[23:16];
				default: bcol_q[7:0] <= mul_p[23:16];
			endcase
		end
		if (state_q == S_RD) begin
			rd_q <= store[cnt_q];
			rvld_q <= vld_q[cnt_q];
		end
		if (emit) begin
			store[cnt_q] <= color;
			oidx_q <= cnt_q;
			ocol_q <= color;
			olast_q <= (cnt_q == LAST);
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.pixel_index = oidx_q;
	assign out_ch.red = ocol_q[23:16];
	assign out_ch.green = ocol_q[15:8];
	assign out_ch.blue = ocol_q[7:0];
	assign out_ch.last_pixel = olast_q;

	`LSEG_ASSERT(a_last_idx, out_ch.valid && out_ch.last_pixel |-> out_ch.pixel_index == LAST, "last pixel flag on wrong index")
	`LSEG_ASSERT(a_busy, in_ch.valid && in_ch.ready && go && cfg.effect_mode <= FX_BREATH |=> !in_ch.ready, "rendering frame did not block input")
	`LSEG_ASSERT(a_head_range, head_q <= LAST, "head position out of range")

endmodule
